>>> rtl/core/rmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W_CNT     = 32;
  localparam int W_VAL     = 32;
  localparam int W_SQ      = 63;
  localparam int W_OPND    = 64;
  localparam int W_WIDE    = 128;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  localparam logic [W_CNT-1:0] CNT_MAX = {W_CNT{1'b1}};
  localparam logic [W_SQ-1:0]  SQ_MAX  = {W_SQ{1'b1}};

  typedef struct packed {
    logic                    opcode;
    logic                    is_missing;
    logic signed [W_VAL-1:0] sample;
    logic [W_CNT-1:0]        part_count;
    logic signed [W_VAL-1:0] part_mean;
    logic [W_SQ-1:0]         part_sq_dev;
  } rmv_in_t;

  typedef struct packed {
    logic [W_CNT-1:0]        total_count;
    logic signed [W_VAL-1:0] running_mean;
    logic [W_SQ-1:0]         sq_dev_sum;
    logic [W_SQ-1:0]         variance;
  } rmv_out_t;

  // clamp a wide unsigned value to 63 bits
  function automatic logic [W_SQ-1:0] sat63(input logic [W_WIDE-1:0] v);
    sat63 = (|v[W_WIDE-1:W_SQ]) ? SQ_MAX : v[W_SQ-1:0];
  endfunction

  function automatic logic [W_SQ-1:0] add_sat63(input logic [W_SQ-1:0] a,
                                                input logic [W_SQ-1:0] b);
    logic [W_SQ:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat63 = s[W_SQ] ? SQ_MAX : s[W_SQ-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rmv_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rmv_in_if;
  logic             valid;
  logic             ready;
  rmv_pkg::rmv_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rmv_out_if;
  logic              valid;
  logic              ready;
  rmv_pkg::rmv_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rmv_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module rmv_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rmv_pkg::W_OPND-1:0]    a,
  input  wire logic [rmv_pkg::W_OPND-1:0]    b,
  output logic                               busy,
  output logic                               done,
  output logic [rmv_pkg::W_WIDE-1:0]         prod
);

  localparam int N = rmv_pkg::W_OPND;

  logic [N-1:0]         a_r;
  logic [$clog2(N):0]   steps;
  logic [N:0]           sum;

  assign sum = {1'b0, prod[2*N-1:N]} + (prod[0] ? {1'b0, a_r} : {(N+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= ($clog2(N)+1)'(N);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == ($clog2(N)+1)'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      prod <= {{N{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[N-1:1]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rmv_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle; quotient clamped to 63 bits
module rmv_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rmv_pkg::W_WIDE-1:0]  dividend,
  input  wire logic [rmv_pkg::W_OPND-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic [rmv_pkg::W_SQ-1:0]         quot
);

  localparam int NW = rmv_pkg::W_WIDE;
  localparam int ND = rmv_pkg::W_OPND;

  logic [ND-1:0]         dvs;
  logic [ND-1:0]         rem;
  logic [NW-1:0]         qr;
  logic [$clog2(NW):0]   steps;
  logic [ND:0]           r2;
  logic [ND:0]           diff;
  logic                  ge;

  assign r2   = {rem, qr[NW-1]};
  assign ge   = r2 >= {1'b0, dvs};
  assign diff = r2 - {1'b0, dvs};
  assign quot = rmv_pkg::sat63(qr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= ($clog2(NW)+1)'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == ($clog2(NW)+1)'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      qr  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[ND-1:0] : r2[ND-1:0];
      qr  <= {qr[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/running_mean_variance.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// items     in   opcode, is_missing, sample, part_count, part_mean, part_sq_dev
// results   out  total_count, running_mean, sq_dev_sum, variance
//
// One item at a time. A sequencer drives one shift-add multiplier and one
// restoring divider. Add: divide, multiply, then divide for variance; merge:
// three multiplies and three divides; a missing sample, an empty partial or a
// merge into an empty accumulator: only the variance divide. The variance divide
// is skipped when the count is below two. Reset clears count, mean and m2.
// The result sits in an output register, so a new item is taken while it waits.
module running_mean_variance #(
  parameter int FRAC_BITS = rmv_pkg::FRAC_BITS
) (
  input wire logic   clk,
  input wire logic   rst,
  rmv_in_if.sink     items,
  rmv_out_if.source  results
);

  localparam int WC = rmv_pkg::W_CNT;
  localparam int WV = rmv_pkg::W_VAL;
  localparam int WS = rmv_pkg::W_SQ;
  localparam int WO = rmv_pkg::W_OPND;
  localparam int WW = rmv_pkg::W_WIDE;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_PREP    = 13'b0000000000010,
    S_ADD_DIV = 13'b0000000000100,
    S_ADD_E   = 13'b0000000001000,
    S_ADD_MUL = 13'b0000000010000,
    S_M_MUL1  = 13'b0000000100000,
    S_M_DIV1  = 13'b0000001000000,
    S_M_MUL2  = 13'b0000010000000,
    S_M_MUL3  = 13'b0000100000000,
    S_M_DIV2  = 13'b0001000000000,
    S_VAR     = 13'b0010000000000,
    S_VAR_DIV = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // accumulator
  logic [WC-1:0]        cnt;
  logic signed [WV-1:0] mean;
  logic [WS-1:0]        m2;

  // held item and working values
  logic                 op;
  logic                 miss;
  logic signed [WV-1:0] x;
  logic [WC-1:0]        nb;
  logic signed [WV-1:0] pm;
  logic [WS-1:0]        psd;
  logic [WV:0]          dabs;
  logic                 dneg;
  logic [WC:0]          ntot;
  logic [2*WC-1:0]      nanb;
  logic [WS-1:0]        var_r;
  logic                 ovalid;

  // shared units
  logic          mul_start, mul_busy, mul_done;
  logic [WO-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_prod;
  logic          div_start, div_busy, div_done;
  logic [WW-1:0] div_dvd;
  logic [WO-1:0] div_dvs;
  logic [WS-1:0] div_q;

  rmv_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  rmv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  // datapath terms
  logic signed [WV:0] d_sel;
  logic [WV:0]        d_mag;
  logic [WC-1:0]      nsat;
  logic signed [WV:0] mean_upd;
  logic signed [WV:0] e_val;
  logic [WV:0]        e_mag;
  logic [WW-1:0]      prod_shr;
  logic [WS-1:0]      t63;
  logic               accept;
  logic               out_load;

  assign accept   = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);

  // Welford and Chan both start from the signed gap to the current mean
  assign d_sel = (op == rmv_pkg::OP_MERGE) ? ({pm[WV-1], pm} - {mean[WV-1], mean})
                                            : ({x[WV-1], x} - {mean[WV-1], mean});
  assign d_mag = d_sel[WV] ? (WV+1)'(-d_sel) : d_sel;
  assign nsat  = (cnt == rmv_pkg::CNT_MAX) ? cnt : cnt + 1'b1;

  // quotient never exceeds |d|, so its low 33 bits carry it
  assign mean_upd = dneg ? ({mean[WV-1], mean} - $signed(div_q[WV:0]))
                         : ({mean[WV-1], mean} + $signed(div_q[WV:0]));

  assign e_val = {x[WV-1], x} - {mean[WV-1], mean};
  assign e_mag = e_val[WV] ? (WV+1)'(-e_val) : e_val;

  assign prod_shr = mul_prod >> FRAC_BITS;
  assign t63      = rmv_pkg::sat63(prod_shr);

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_PREP;
      end
      S_PREP: begin
        if (op == rmv_pkg::OP_ADD) begin
          if (miss) begin
            state_next = S_VAR;
          end else begin
            div_start  = 1'b1;
            div_dvd    = {{(WW-WV-1){1'b0}}, d_mag};
            div_dvs    = {{(WO-WC){1'b0}}, nsat};
            state_next = S_ADD_DIV;
          end
        end else if (nb == '0 || cnt == '0) begin
          state_next = S_VAR;
        end else begin
          mul_start  = 1'b1;
          mul_a      = {{(WO-WV-1){1'b0}}, d_mag};
          mul_b      = {{(WO-WC){1'b0}}, nb};
          state_next = S_M_MUL1;
        end
      end
      S_ADD_DIV: begin
        if (div_done) state_next = S_ADD_E;
      end
      S_ADD_E: begin
        mul_start  = 1'b1;
        mul_a      = {{(WO-WV-1){1'b0}}, dabs};
        mul_b      = {{(WO-WV-1){1'b0}}, e_mag};
        state_next = S_ADD_MUL;
      end
      S_ADD_MUL: begin
        if (mul_done) state_next = S_VAR;
      end
      S_M_MUL1: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_dvd    = mul_prod;
          div_dvs    = {{(WO-WC-1){1'b0}}, ntot};
          state_next = S_M_DIV1;
        end
      end
      S_M_DIV1: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = {{(WO-WV-1){1'b0}}, dabs};
          mul_b      = {{(WO-WV-1){1'b0}}, dabs};
          state_next = S_M_MUL2;
        end
      end
      S_M_MUL2: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {{(WO-WS){1'b0}}, t63};
          mul_b      = nanb;
          state_next = S_M_MUL3;
        end
      end
      S_M_MUL3: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_dvd    = mul_prod;
          div_dvs    = {{(WO-WC-1){1'b0}}, ntot};
          state_next = S_M_DIV2;
        end
      end
      S_M_DIV2: begin
        if (div_done) state_next = S_VAR;
      end
      S_VAR: begin
        if (cnt < WC'(2)) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          div_dvd    = {{(WW-WS){1'b0}}, m2};
          div_dvs    = {{(WO-WC){1'b0}}, cnt - 1'b1};
          state_next = S_VAR_DIV;
        end
      end
      S_VAR_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!ovalid || results.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      cnt    <= '0;
      mean   <= '0;
      m2     <= '0;
    end else begin
      state <= state_next;
      if (out_load) ovalid <= 1'b1;
      else if (results.ready) ovalid <= 1'b0;

      if (state == S_PREP && op == rmv_pkg::OP_MERGE && nb != '0 && cnt == '0) begin
        // empty accumulator takes the partial as is
        cnt  <= nb;
        mean <= pm;
        m2   <= psd;
      end
      if (state == S_ADD_DIV && div_done) begin
        cnt  <= nsat;
        mean <= mean_upd[WV-1:0];
      end
      if (state == S_ADD_MUL && mul_done) m2 <= rmv_pkg::add_sat63(m2, t63);
      if (state == S_M_DIV1 && div_done) mean <= mean_upd[WV-1:0];
      if (state == S_M_DIV2 && div_done) begin
        m2  <= rmv_pkg::add_sat63(rmv_pkg::add_sat63(m2, psd), div_q);
        cnt <= ntot[WC] ? rmv_pkg::CNT_MAX : ntot[WC-1:0];
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= items.data.opcode;
      miss <= items.data.is_missing;
      x    <= items.data.sample;
      nb   <= items.data.part_count;
      pm   <= items.data.part_mean;
      psd  <= items.data.part_sq_dev;
    end
    if (state == S_PREP) begin
      dabs <= d_mag;
      dneg <= d_sel[WV];
      ntot <= {1'b0, cnt} + {1'b0, nb};
      nanb <= cnt * nb;
    end
    if (state == S_VAR && cnt < WC'(2)) var_r <= '0;
    if (state == S_VAR_DIV && div_done) var_r <= div_q;
    if (out_load) begin
      results.data.total_count  <= cnt;
      results.data.running_mean <= mean;
      results.data.sq_dev_sum   <= m2;
      results.data.variance     <= var_r;
    end
  end

  assign results.valid = ovalid;

  // ---- checks ----
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> cnt >= $past(cnt))
    else $error("sample count went down");

  a_small_count_var: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.total_count < WC'(2) |-> results.data.variance == '0)
    else $error("variance nonzero with fewer than two samples");

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PREP && !mul_busy && !div_busy)
    else $error("item taken while a unit was running");

endmodule

`default_nettype wire

>>> dv/rmv_checker.sv
`timescale 1ns / 1ps

// Watches both channels, tracks accumulator state and compares each result.
module rmv_checker (
  input  logic clk,
  input  logic rst,
  rmv_in_if    items,
  rmv_out_if   results,
  output int   fails,
  output int   pending
);

  localparam logic [127:0] CLAMP63 = {65'd0, {63{1'b1}}};

  logic [31:0]        acc_n;
  logic [31:0]        acc_mu;
  logic [62:0]        acc_m2;
  rmv_pkg::rmv_out_t  summary_q[$];

  function automatic logic [62:0] clamp63(input logic [127:0] v);
    return (v > CLAMP63) ? {63{1'b1}} : v[62:0];
  endfunction

  function automatic logic [62:0] sum63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  function automatic logic [63:0] absval(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic welford_add(input logic signed [31:0] x);
    logic [63:0]  n, ad, ae, q;
    longint       mu, d, nm, xl;
    logic [127:0] prod;
    n    = (acc_n != rmv_pkg::CNT_MAX) ? {32'd0, acc_n} + 64'd1 : {32'd0, acc_n};
    mu   = longint'($signed(acc_mu));
    xl   = longint'(x);
    d    = xl - mu;
    ad   = absval(d);
    q    = ad / n;
    nm   = (d < 0) ? mu - longint'(q) : mu + longint'(q);
    ae   = absval(xl - nm);
    prod = {64'd0, ad} * {64'd0, ae};
    acc_n  = n[31:0];
    acc_mu = nm[31:0];
    acc_m2 = sum63(acc_m2, clamp63(prod >> rmv_pkg::FRAC_BITS));
  endtask

  task automatic chan_merge(input logic [31:0] nb, input logic signed [31:0] pm,
                            input logic [62:0] psd);
    logic [63:0]  n, ad, q, nanb;
    logic [62:0]  t, term;
    longint       mu, d, nm;
    logic [127:0] wide;
    if (nb == 0) return;
    if (acc_n == 0) begin
      acc_n  = nb;
      acc_mu = pm;
      acc_m2 = psd;
      return;
    end
    n    = {32'd0, acc_n} + {32'd0, nb};
    mu   = longint'($signed(acc_mu));
    d    = longint'(pm) - mu;
    ad   = absval(d);
    wide = ({64'd0, ad} * {96'd0, nb}) / {64'd0, n};
    q    = {1'b0, clamp63(wide)};
    nm   = (d < 0) ? mu - longint'(q) : mu + longint'(q);
    t    = clamp63(({64'd0, ad} * {64'd0, ad}) >> rmv_pkg::FRAC_BITS);
    nanb = {32'd0, acc_n} * {32'd0, nb};
    term = clamp63(({65'd0, t} * {64'd0, nanb}) / {64'd0, n});
    acc_m2 = sum63(sum63(acc_m2, psd), term);
    acc_mu = nm[31:0];
    acc_n  = (n > 64'hFFFF_FFFF) ? rmv_pkg::CNT_MAX : n[31:0];
  endtask

  function automatic rmv_pkg::rmv_out_t snapshot();
    rmv_pkg::rmv_out_t s;
    s.total_count  = acc_n;
    s.running_mean = acc_mu;
    s.sq_dev_sum   = acc_m2;
    s.variance     = (acc_n < 2) ? '0 : acc_m2 / {31'd0, acc_n - 32'd1};
    return s;
  endfunction

  always @(posedge clk) begin
    rmv_pkg::rmv_out_t exp_s, got;
    if (rst) begin
      acc_n  = '0;
      acc_mu = '0;
      acc_m2 = '0;
      summary_q.delete();
      fails   <= 0;
      pending <= 0;
    end else begin
      if (results.valid && results.ready) begin
        got = results.data;
        if (summary_q.size() == 0) begin
          $error("result with nothing expected: count %0d", got.total_count);
          fails <= fails + 1;
        end else begin
          exp_s = summary_q.pop_front();
          if (got !== exp_s) fails <= fails + 1;
          if (got.total_count !== exp_s.total_count)
            $error("total_count exp %0d got %0d", exp_s.total_count, got.total_count);
          if (got.running_mean !== exp_s.running_mean)
            $error("running_mean exp %0d got %0d", exp_s.running_mean, got.running_mean);
          if (got.sq_dev_sum !== exp_s.sq_dev_sum)
            $error("sq_dev_sum exp %0d got %0d", exp_s.sq_dev_sum, got.sq_dev_sum);
          if (got.variance !== exp_s.variance)
            $error("variance exp %0d got %0d", exp_s.variance, got.variance);
        end
      end
      if (items.valid && items.ready) begin
        if (items.data.opcode == rmv_pkg::OP_MERGE)
          chan_merge(items.data.part_count, items.data.part_mean, items.data.part_sq_dev);
        else if (!items.data.is_missing)
          welford_add(items.data.sample);
        summary_q.push_back(snapshot());
      end
      pending <= summary_q.size();
    end
  end
endmodule

>>> dv/tb_running_mean_variance.sv
`timescale 1ns / 1ps

// Stimulus and verdict. Checking lives in rmv_checker.
module tb_running_mean_variance;

  localparam int N_RANDOM  = 1750;
  localparam int STALL_MAX = 20000;  // cycles with no handshake before giving up

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  logic calm = 1'b0;       // suppress random idling on both sides
  logic hold_off = 1'b0;   // receiver long stall

  rmv_in_if  items();
  rmv_out_if results();

  always #2 clk = ~clk;

  running_mean_variance dut (.clk(clk), .rst(rst), .items(items), .results(results));

  rmv_checker chk (
    .clk(clk), .rst(rst), .items(items), .results(results),
    .fails(fails), .pending(pending)
  );

  initial begin
    items.valid   = 1'b0;
    items.data    = '0;
    results.ready = 1'b0;
  end

  // receiver: ~7% idle, none while calm, idle throughout the hold-off
  always @(negedge clk)
    results.ready <= !rst && !hold_off && (calm || $urandom_range(99) >= 7);

  // watchdog: any handshake resets the count
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((items.valid && items.ready) || (results.valid && results.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drive one item; returns at the falling edge after acceptance so the
  // next call can keep valid high without a gap.
  task automatic send(input rmv_pkg::rmv_in_t it);
    while (!calm && $urandom_range(99) < 7) begin
      items.valid = 1'b0;
      @(negedge clk);
    end
    items.valid = 1'b1;
    items.data  = it;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic rmv_pkg::rmv_in_t add_item(input logic signed [31:0] x,
                                                input logic miss);
    rmv_pkg::rmv_in_t it;
    it            = '0;
    it.opcode     = rmv_pkg::OP_ADD;
    it.is_missing = miss;
    it.sample     = x;
    // part fields are don't-care on an add; fill them to show that
    it.part_count  = $urandom;
    it.part_mean   = $urandom;
    it.part_sq_dev = 63'({$urandom, $urandom});
    return it;
  endfunction

  function automatic rmv_pkg::rmv_in_t merge_item(input logic [31:0] nb,
                                                  input logic signed [31:0] pm,
                                                  input logic [62:0] psd);
    rmv_pkg::rmv_in_t it;
    it             = '0;
    it.opcode      = rmv_pkg::OP_MERGE;
    it.is_missing  = 1'($urandom_range(1));
    it.sample      = $urandom;
    it.part_count  = nb;
    it.part_mean   = pm;
    it.part_sq_dev = psd;
    return it;
  endfunction

  // Random item; counts and squared sums stay well short of saturation so
  // the state does not stick at its clamp early in the run.
  function automatic rmv_pkg::rmv_in_t rand_item();
    int          pick;
    logic [31:0] x;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: x = $urandom;                                      // full range
      1: x = $signed($urandom_range(2000)) - 1000;          // near zero
      default: x = ($signed($urandom_range(65535)) - 32768) <<< 8;
    endcase
    if (pick < 10) return add_item(x, 1'b1);
    if (pick < 75) return add_item(x, 1'b0);
    if (pick < 80) return merge_item('0, x, 63'({$urandom, $urandom}));  // empty partial
    return merge_item($urandom_range(64, 1), x, {31'd0, $urandom});
  endfunction

  initial begin
    rmv_pkg::rmv_in_t it;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed ---
    send(add_item(32'sd0, 1'b1));                 // missing sample on empty state
    send(merge_item('0, 32'sd5, 63'd99));         // empty partial on empty state
    send(merge_item(32'd3, 32'sd65536, 63'd1000)); // empty accumulator copies partial
    send(add_item(32'sh7FFF_FFFF, 1'b0));         // largest sample
    send(add_item(32'sh8000_0000, 1'b0));         // smallest sample
    send(add_item(32'sh8000_0000, 1'b1));         // missing, state kept
    send(add_item(32'sd0, 1'b0));
    send(add_item(32'sd1, 1'b0));
    send(add_item(-32'sd1, 1'b0));
    send(merge_item(32'd1, 32'sh7FFF_FFFF, 63'd0));
    send(merge_item(32'd1, 32'sh8000_0000, 63'd0));
    send(merge_item('0, 32'sh7FFF_FFFF, {63{1'b1}})); // ignored despite huge m2
    send(merge_item(32'd1000, 32'sd0, 63'd12345));
    send(add_item(32'sd123456, 1'b0));

    // --- random ---
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        // receiver stalls long while the sender keeps offering
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 700) begin
        // sender drains the pipeline completely before going on
        items.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      calm = (i >= 1000 && i < 1250);
      send(rand_item());
    end
    calm = 1'b0;

    // --- saturation, last since it sticks ---
    send(merge_item(32'd10, 32'sd7, {63{1'b1}}));      // m2 clamps
    send(add_item(32'sd99, 1'b0));
    send(merge_item(32'hFFFF_FFFF, 32'sh8000_0000, 63'({$urandom, $urandom})));  // count clamps
    send(add_item(32'sh7FFF_FFFF, 1'b0));              // add at saturated count
    send(add_item(32'sh8000_0000, 1'b1));
    for (int i = 0; i < 40; i++) begin
      it = $urandom_range(1) ? merge_item($urandom, $urandom, 63'({$urandom, $urandom}))
                             : add_item($urandom, 1'($urandom_range(1)));
      send(it);
    end
    items.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> running_mean_variance.f
rtl/core/rmv_pkg.sv
rtl/core/rmv_if.sv
rtl/core/rmv_mul.sv
rtl/core/rmv_div.sv
rtl/core/running_mean_variance.sv
dv/rmv_checker.sv
dv/tb_running_mean_variance.sv
